>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the recursive lock core.
// Depends on nothing; define SYNTH to compile the macros away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a whole property expression, sampled on the rising clock edge.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("property check failed");
// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/rmwq_pkg.sv
// Package of the recursive lock core: sizes, codes and transaction types.
// Depends on nothing; used by every module of the core.
`default_nettype none

package rmwq_pkg;

    localparam int MAX_THREADS = 16;
    localparam int MAX_HOLD    = 255;

    localparam int TID_W   = 4;
    localparam int NUM_IDS = 2 ** TID_W;
    localparam int RING_AW = $clog2(MAX_THREADS);
    localparam int FILL_W  = $clog2(MAX_THREADS + 1);
    localparam int HOLD_W  = $clog2(MAX_HOLD + 1);
    localparam int LEVEL_W = 8;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_REENTERED = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_PARTIAL   = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_OWNER = 3'd5,
        ST_WAITING   = 3'd6,
        ST_OVERFLOW  = 3'd7
    } status_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [TID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               wake_valid;
        logic [TID_W-1:0]   wake_thread;
        logic               owner_valid;
        logic [TID_W-1:0]   owner_thread;
        logic [LEVEL_W-1:0] hold_level;
    } rsp_t;

    // Commands from the lock logic to the wait queue.
    typedef struct packed {
        logic             push;
        logic [TID_W-1:0] push_tid;
        logic             pop;
    } ring_cmd_t;

    // Status of the wait queue as seen by the lock logic.
    typedef struct packed {
        logic             waiting;
        logic             full;
        logic             empty;
        logic [TID_W-1:0] head_tid;
    } ring_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rmwq_wait_ring.sv
// FIFO of waiting thread ids with per-thread waiting marks.
// Depends on rmwq_pkg.
`default_nettype none

module rmwq_wait_ring (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [rmwq_pkg::TID_W-1:0] query_tid,
    input  wire rmwq_pkg::ring_cmd_t        cmd,
    output rmwq_pkg::ring_stat_t            stat
);

    logic [rmwq_pkg::TID_W-1:0]   ring_reg [rmwq_pkg::MAX_THREADS];
    logic [rmwq_pkg::RING_AW-1:0] head_reg, head_next;
    logic [rmwq_pkg::RING_AW-1:0] tail_reg, tail_next;
    logic [rmwq_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [rmwq_pkg::NUM_IDS-1:0] mark_reg, mark_next;

    localparam logic [rmwq_pkg::RING_AW-1:0] LAST_POS =
        rmwq_pkg::RING_AW'(rmwq_pkg::MAX_THREADS - 1);

    always_comb
    begin
        stat.waiting  = mark_reg[query_tid];
        stat.full     = (fill_reg == rmwq_pkg::FILL_W'(rmwq_pkg::MAX_THREADS));
        stat.empty    = (fill_reg == '0);
        stat.head_tid = ring_reg[head_reg];
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        mark_next = mark_reg;
        if (cmd.push)
        begin
            tail_next = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
            mark_next[cmd.push_tid] = 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
            mark_next[ring_reg[head_reg]] = 1'b0;
        end
    end

    // Entries carry no reset: an entry is only read after it was pushed.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_reg[tail_reg] <= cmd.push_tid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            mark_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            mark_reg <= mark_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/recursive_mutex_wait_queue_core.sv
// An accepted request passes the input register and the result register before done.
// Throughput: one request per cycle; busy is never raised, as each request needs
// only the owner registers and the status of the wait queue.
// The receiver cannot stall; done is high for exactly one cycle, rsp holds to the next.
// Reset (rst_n, asynchronous, active low) frees the lock and empties the wait queue.
`default_nettype none
`include "assert_macros.svh"

module recursive_mutex_wait_queue_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rmwq_pkg::req_t req,
    output logic                done,
    output rmwq_pkg::rsp_t      rsp
);

    // Input register: the accepted transaction is registered here before the decision.
    logic           req_valid_reg;
    rmwq_pkg::req_t req_reg;

    // Lock ownership state.
    logic                          held_reg, held_next;
    logic [rmwq_pkg::TID_W-1:0]    holder_reg, holder_next;
    logic [rmwq_pkg::HOLD_W-1:0]   count_reg, count_next;

    // Result register.
    logic           done_reg;
    rmwq_pkg::rsp_t rsp_reg, rsp_next;

    rmwq_pkg::ring_cmd_t  ring_cmd;
    rmwq_pkg::ring_stat_t ring_stat;

    logic is_owner;

    // Nothing in the datapath ever holds a request off.
    assign busy = 1'b0;

    rmwq_wait_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .query_tid (req_reg.thread_id),
        .cmd       (ring_cmd),
        .stat      (ring_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    assign is_owner = held_reg && (holder_reg == req_reg.thread_id);

    // The whole decision for one request. On an acquire the waiting mark comes first, so a
    // queued thread is refused even when the lock is free; the owner check then
    // comes before the free check, and the queue-full check comes last.
    always_comb
    begin
        held_next            = held_reg;
        holder_next          = holder_reg;
        count_next           = count_reg;
        ring_cmd.push        = 1'b0;
        ring_cmd.push_tid    = req_reg.thread_id;
        ring_cmd.pop         = 1'b0;
        rsp_next.status      = rmwq_pkg::ST_NOT_OWNER;
        rsp_next.wake_valid  = 1'b0;
        rsp_next.wake_thread = '0;

        if (req_reg.opcode == rmwq_pkg::OP_ACQUIRE)
        begin
            priority if (ring_stat.waiting)
            begin
                rsp_next.status = rmwq_pkg::ST_WAITING;
            end
            else if (is_owner)
            begin
                if (count_reg >= rmwq_pkg::HOLD_W'(rmwq_pkg::MAX_HOLD))
                begin
                    rsp_next.status = rmwq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    count_next      = count_reg + 1'b1;
                    rsp_next.status = rmwq_pkg::ST_REENTERED;
                end
            end
            else if (!held_reg)
            begin
                held_next       = 1'b1;
                holder_next     = req_reg.thread_id;
                count_next      = rmwq_pkg::HOLD_W'(1);
                rsp_next.status = rmwq_pkg::ST_GRANTED;
            end
            else if (ring_stat.full)
            begin
                rsp_next.status = rmwq_pkg::ST_OVERFLOW;
            end
            else
            begin
                ring_cmd.push   = req_valid_reg;
                rsp_next.status = rmwq_pkg::ST_QUEUED;
            end
        end
        else
        begin
            priority if (!is_owner)
            begin
                rsp_next.status = rmwq_pkg::ST_NOT_OWNER;
            end
            else if (count_reg > rmwq_pkg::HOLD_W'(1))
            begin
                count_next      = count_reg - 1'b1;
                rsp_next.status = rmwq_pkg::ST_PARTIAL;
            end
            else
            begin
                // Last release: free the lock and wake the oldest waiter, if any.
                held_next       = 1'b0;
                holder_next     = '0;
                count_next      = '0;
                rsp_next.status = rmwq_pkg::ST_FULL;
                if (!ring_stat.empty)
                begin
                    ring_cmd.pop         = req_valid_reg;
                    rsp_next.wake_valid  = 1'b1;
                    rsp_next.wake_thread = ring_stat.head_tid;
                end
            end
        end

        rsp_next.owner_valid  = held_next;
        rsp_next.owner_thread = held_next ? holder_next : '0;
        rsp_next.hold_level   = rmwq_pkg::LEVEL_W'(count_next);
    end

    // State only moves when a transaction sits in the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= 1'b0;
            holder_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
            if (req_valid_reg)
            begin
                held_reg   <= held_next;
                holder_reg <= holder_next;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Every accepted transaction yields its result through the input and result registers.
    `ASSERT_PROP(a_latency, clk, rst_n, start && !busy |=> ##1 done)
    // A held lock always has a non-zero hold count.
    `ASSERT_IMPLY(a_held_count, clk, rst_n, held_reg, count_reg != '0)
    // A woken waiter only comes with a full release, which leaves the lock free.
    `ASSERT_IMPLY(a_wake_free, clk, rst_n, done && rsp.wake_valid,
                  !rsp.owner_valid && (rsp.status == rmwq_pkg::ST_FULL))

endmodule

`default_nettype wire
